### rtl/ccm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the contour cross moment matcher.
// Used by the controller, the datapath and the top level; no dependencies.
package ccm_pkg;

    localparam int CoordW   = 16;
    localparam int RelW     = CoordW + 1;
    localparam int WeightW  = 16;
    localparam int LenW     = 24;
    localparam int DivW     = LenW + 3;
    localparam int SumW     = 64;
    localparam int MomW     = 31;
    localparam int TermW    = 32;
    localparam int CloseW   = 64;
    localparam int StepW    = 6;
    localparam int MomCount = 4;
    localparam int IdxW     = 2;

    typedef struct packed {
        logic            capture;
        logic            seed;
        logic            rel;
        logic            mul;
        logic            sum;
        logic            wmul;
        logic            acc;
        logic            adv;
        logic            div_load;
        logic            div_step;
        logic            div_store;
        logic            fin;
        logic            sq_s;
        logic            sq_c;
        logic            out_load;
        logic [IdxW-1:0] k;
    } cmd_t;

    typedef struct packed {
        logic last;
    } sts_t;

endpackage

### rtl/ccm_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the contour cross moment matcher: issues per-point moment
// steps, the shared divider passes and the result load. Depends on ccm_pkg.
module ccm_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  ccm_pkg::sts_t sts,
    output ccm_pkg::cmd_t cmd
);

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_PREP   = 13'b0000000000010,
        ST_MUL    = 13'b0000000000100,
        ST_SUM    = 13'b0000000001000,
        ST_WMUL   = 13'b0000000010000,
        ST_ACC    = 13'b0000000100000,
        ST_DLOAD  = 13'b0000001000000,
        ST_DSTEP  = 13'b0000010000000,
        ST_DSTORE = 13'b0000100000000,
        ST_FIN    = 13'b0001000000000,
        ST_SQS    = 13'b0010000000000,
        ST_SQC    = 13'b0100000000000,
        ST_OUT    = 13'b1000000000000
    } state_t;

    state_t                       state_reg, state_next;
    logic [ccm_pkg::IdxW-1:0]     k_reg, k_next;
    logic [ccm_pkg::StepW-1:0]    step_reg, step_next;
    logic                         first_reg, first_next;
    logic                         valid_reg, valid_next;
    logic                         out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = valid_reg;
    assign out_free = !valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        step_next  = step_reg;
        first_next = first_reg;
        valid_next = valid_reg && !m_ready;
        cmd        = '0;
        cmd.k      = k_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP: begin
                k_next = '0;
                if (first_reg) begin
                    cmd.seed   = 1'b1;
                    first_next = 1'b0;
                    state_next = sts.last ? ST_DLOAD : ST_IDLE;
                end else begin
                    cmd.rel    = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_WMUL;
            end
            ST_WMUL: begin
                cmd.wmul   = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc = 1'b1;
                k_next  = k_reg + 1'b1;
                if (k_reg == ccm_pkg::IdxW'(ccm_pkg::MomCount - 1)) begin
                    cmd.adv    = 1'b1;
                    state_next = sts.last ? ST_DLOAD : ST_IDLE;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_DLOAD: begin
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = ST_DSTEP;
            end
            ST_DSTEP: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == '1) begin
                    state_next = ST_DSTORE;
                end
            end
            ST_DSTORE: begin
                cmd.div_store = 1'b1;
                k_next        = k_reg + 1'b1;
                if (k_reg == ccm_pkg::IdxW'(ccm_pkg::MomCount - 1)) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_DLOAD;
                end
            end
            ST_FIN: begin
                cmd.fin    = 1'b1;
                state_next = ST_SQS;
            end
            ST_SQS: begin
                cmd.sq_s   = 1'b1;
                state_next = ST_SQC;
            end
            ST_SQC: begin
                cmd.sq_c   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    valid_next   = 1'b1;
                    first_next   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            step_reg  <= '0;
            first_reg <= 1'b1;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            step_reg  <= step_next;
            first_reg <= first_next;
            valid_reg <= valid_next;
        end
    end

endmodule

### rtl/ccm_datapath.sv
`timescale 1ns / 1ps
// Datapath: point registers, segment term multipliers, saturating
// accumulators, shared bit-serial divider and result registers. Uses ccm_pkg.
module ccm_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  ccm_pkg::cmd_t                      cmd,
    output ccm_pkg::sts_t                      sts,
    input  logic                               cfg_we,
    input  logic        [ccm_pkg::LenW-1:0]    cfg_data,
    input  logic signed [ccm_pkg::CoordW-1:0]  ref_x,
    input  logic signed [ccm_pkg::CoordW-1:0]  ref_y,
    input  logic signed [ccm_pkg::CoordW-1:0]  obj_x,
    input  logic signed [ccm_pkg::CoordW-1:0]  obj_y,
    input  logic        [ccm_pkg::WeightW-1:0] seg_weight,
    input  logic                               last_point,
    output logic signed [ccm_pkg::MomW-1:0]    moment_xx,
    output logic signed [ccm_pkg::MomW-1:0]    moment_yx,
    output logic signed [ccm_pkg::MomW-1:0]    moment_xy,
    output logic signed [ccm_pkg::MomW-1:0]    moment_yy,
    output logic signed [ccm_pkg::TermW-1:0]   sine_term,
    output logic signed [ccm_pkg::TermW-1:0]   cosine_term,
    output logic        [ccm_pkg::CloseW-1:0]  closeness
);

    localparam int AW = ccm_pkg::CoordW + 1;
    localparam int BW = ccm_pkg::RelW + 1;
    localparam int P1W = AW + BW;
    localparam int P2W = ccm_pkg::CoordW + ccm_pkg::RelW;
    localparam int TW = P1W + 3;
    localparam int PW = TW + ccm_pkg::WeightW + 1;
    localparam int SW = ccm_pkg::SumW;
    localparam int DW = ccm_pkg::DivW;

    logic        [ccm_pkg::LenW-1:0]    len_reg;
    logic signed [ccm_pkg::CoordW-1:0]  rx_reg, ry_reg, ox_reg, oy_reg;
    logic        [ccm_pkg::WeightW-1:0] w_reg;
    logic                               last_reg;
    logic signed [ccm_pkg::CoordW-1:0]  first_x_reg, first_y_reg, prev_rx_reg, prev_ry_reg;
    logic signed [ccm_pkg::RelW-1:0]    cx_reg, cy_reg, prev_cx_reg, prev_cy_reg;
    logic signed [SW-1:0]               sum_reg [ccm_pkg::MomCount];
    logic signed [P1W-1:0]              p1_reg;
    logic signed [P2W-1:0]              p2_reg, p3_reg;
    logic signed [TW-1:0]               t_reg;
    logic signed [PW-1:0]               prod_reg;
    logic        [SW-1:0]               n_reg;
    logic        [DW-1:0]               rem_reg;
    logic        [SW-1:0]               q_reg;
    logic                               neg_reg;
    logic signed [ccm_pkg::MomW-1:0]    mom_reg [ccm_pkg::MomCount];
    logic signed [ccm_pkg::TermW-1:0]   sn_reg, cs_reg;
    logic        [ccm_pkg::CloseW-1:0]  sq_reg, clos_reg;
    logic signed [ccm_pkg::MomW-1:0]    out_mom_reg [ccm_pkg::MomCount];
    logic signed [ccm_pkg::TermW-1:0]   out_sn_reg, out_cs_reg;
    logic        [ccm_pkg::CloseW-1:0]  out_clos_reg;

    logic signed [ccm_pkg::CoordW-1:0]  pr, cr;
    logic signed [ccm_pkg::RelW-1:0]    po, co;
    logic signed [AW-1:0]               a_sum;
    logic signed [BW-1:0]               b_sum;
    logic signed [SW:0]                 acc_ext;
    logic signed [SW-1:0]               acc_val, sum_sel;
    logic        [ccm_pkg::LenW-1:0]    len_eff;
    logic        [DW-1:0]               divisor;
    logic        [SW-1:0]               mag;
    logic        [DW:0]                 rem_sh;
    logic                               ge;
    logic        [SW-1:0]               q_sat;
    logic        [ccm_pkg::TermW-1:0]   sa, ca;

    assign sts.last = last_reg;

    assign pr    = cmd.k[1] ? prev_ry_reg : prev_rx_reg;
    assign cr    = cmd.k[1] ? ry_reg : rx_reg;
    assign po    = cmd.k[0] ? prev_cy_reg : prev_cx_reg;
    assign co    = cmd.k[0] ? cy_reg : cx_reg;
    assign a_sum = AW'(pr) + AW'(cr);
    assign b_sum = BW'(po) + BW'(co);

    assign sum_sel = sum_reg[cmd.k];
    assign acc_ext = (SW + 1)'(sum_sel) + (SW + 1)'(prod_reg);
    always_comb begin
        if (acc_ext[SW] != acc_ext[SW-1]) begin
            acc_val = acc_ext[SW] ? {1'b1, {(SW - 1){1'b0}}} : {1'b0, {(SW - 1){1'b1}}};
        end else begin
            acc_val = acc_ext[SW-1:0];
        end
    end

    assign len_eff = (len_reg == '0) ? ccm_pkg::LenW'(1) : len_reg;
    assign divisor = {1'b0, len_eff, 2'b00} + {2'b00, len_eff, 1'b0};
    assign mag     = sum_sel[SW-1] ? (SW'(0) - SW'(sum_sel)) : SW'(sum_sel);
    assign rem_sh  = {rem_reg, n_reg[SW-1]};
    assign ge      = rem_sh >= {1'b0, divisor};

    always_comb begin
        if (neg_reg) begin
            q_sat = (q_reg > (SW'(1) << (ccm_pkg::MomW - 1))) ?
                    (SW'(1) << (ccm_pkg::MomW - 1)) : q_reg;
            q_sat = SW'(0) - q_sat;
        end else begin
            q_sat = (q_reg > ((SW'(1) << (ccm_pkg::MomW - 1)) - SW'(1))) ?
                    ((SW'(1) << (ccm_pkg::MomW - 1)) - SW'(1)) : q_reg;
        end
    end

    assign sa = sn_reg[ccm_pkg::TermW-1] ? (ccm_pkg::TermW'(0) - sn_reg) : sn_reg;
    assign ca = cs_reg[ccm_pkg::TermW-1] ? (ccm_pkg::TermW'(0) - cs_reg) : cs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= ccm_pkg::LenW'(1);
        end else if (cfg_we) begin
            len_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            rx_reg   <= ref_x;
            ry_reg   <= ref_y;
            ox_reg   <= obj_x;
            oy_reg   <= obj_y;
            w_reg    <= seg_weight;
            last_reg <= last_point;
        end
        if (cmd.seed) begin
            first_x_reg <= ox_reg;
            first_y_reg <= oy_reg;
            prev_rx_reg <= rx_reg;
            prev_ry_reg <= ry_reg;
            prev_cx_reg <= '0;
            prev_cy_reg <= '0;
            for (int i = 0; i < ccm_pkg::MomCount; i++) begin
                sum_reg[i] <= '0;
            end
        end
        if (cmd.rel) begin
            cx_reg <= ccm_pkg::RelW'(ox_reg) - ccm_pkg::RelW'(first_x_reg);
            cy_reg <= ccm_pkg::RelW'(oy_reg) - ccm_pkg::RelW'(first_y_reg);
        end
        if (cmd.mul) begin
            p1_reg <= P1W'(a_sum) * P1W'(b_sum);
            p2_reg <= P2W'(pr) * P2W'(co);
            p3_reg <= P2W'(cr) * P2W'(po);
        end
        if (cmd.sum) begin
            t_reg <= (TW'(p1_reg) <<< 1) - TW'(p2_reg) - TW'(p3_reg);
        end
        if (cmd.wmul) begin
            prod_reg <= PW'(t_reg) * PW'($signed({1'b0, w_reg}));
        end
        if (cmd.acc) begin
            sum_reg[cmd.k] <= acc_val;
        end
        if (cmd.adv) begin
            prev_rx_reg <= rx_reg;
            prev_ry_reg <= ry_reg;
            prev_cx_reg <= cx_reg;
            prev_cy_reg <= cy_reg;
        end
        if (cmd.div_load) begin
            n_reg   <= mag + SW'(divisor >> 1);
            rem_reg <= '0;
            q_reg   <= '0;
            neg_reg <= sum_sel[SW-1];
        end
        if (cmd.div_step) begin
            n_reg   <= {n_reg[SW-2:0], 1'b0};
            rem_reg <= ge ? DW'(rem_sh - {1'b0, divisor}) : rem_sh[DW-1:0];
            q_reg   <= {q_reg[SW-2:0], ge};
        end
        if (cmd.div_store) begin
            mom_reg[cmd.k] <= q_sat[ccm_pkg::MomW-1:0];
        end
        if (cmd.fin) begin
            sn_reg <= ccm_pkg::TermW'(mom_reg[1]) - ccm_pkg::TermW'(mom_reg[2]);
            cs_reg <= ccm_pkg::TermW'(mom_reg[0]) + ccm_pkg::TermW'(mom_reg[3]);
        end
        if (cmd.sq_s) begin
            sq_reg <= ccm_pkg::CloseW'(sa) * ccm_pkg::CloseW'(sa);
        end
        if (cmd.sq_c) begin
            clos_reg <= sq_reg + ccm_pkg::CloseW'(ca) * ccm_pkg::CloseW'(ca);
        end
        if (cmd.out_load) begin
            for (int i = 0; i < ccm_pkg::MomCount; i++) begin
                out_mom_reg[i] <= mom_reg[i];
            end
            out_sn_reg   <= sn_reg;
            out_cs_reg   <= cs_reg;
            out_clos_reg <= clos_reg;
        end
    end

    assign moment_xx   = out_mom_reg[0];
    assign moment_yx   = out_mom_reg[1];
    assign moment_xy   = out_mom_reg[2];
    assign moment_yy   = out_mom_reg[3];
    assign sine_term   = out_sn_reg;
    assign cosine_term = out_cs_reg;
    assign closeness   = out_clos_reg;

endmodule

### rtl/contour_cross_moment_matcher.sv
`timescale 1ns / 1ps
// Top level of the contour cross moment matcher.
// Instantiates ccm_ctrl and ccm_datapath; uses ccm_pkg.

// The first point of a contour only seeds the start registers; for every later
// point the four moment terms run one after another through one multiply,
// combine, weight and accumulate sequence. A point carrying s_last_point then
// holds the input while one bit-serial divider normalizes the four sums a bit per
// cycle and the sine, cosine and closeness terms are formed. The next point is
// taken while a finished result still waits on the m_ side; only the following
// result waits.
module contour_cross_moment_matcher (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic        [ccm_pkg::LenW-1:0]    cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [ccm_pkg::CoordW-1:0]  s_ref_x,
    input  logic signed [ccm_pkg::CoordW-1:0]  s_ref_y,
    input  logic signed [ccm_pkg::CoordW-1:0]  s_obj_x,
    input  logic signed [ccm_pkg::CoordW-1:0]  s_obj_y,
    input  logic        [ccm_pkg::WeightW-1:0] s_seg_weight,
    input  logic                               s_last_point,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [ccm_pkg::MomW-1:0]    m_moment_xx,
    output logic signed [ccm_pkg::MomW-1:0]    m_moment_yx,
    output logic signed [ccm_pkg::MomW-1:0]    m_moment_xy,
    output logic signed [ccm_pkg::MomW-1:0]    m_moment_yy,
    output logic signed [ccm_pkg::TermW-1:0]   m_sine_term,
    output logic signed [ccm_pkg::TermW-1:0]   m_cosine_term,
    output logic        [ccm_pkg::CloseW-1:0]  m_closeness
);

    ccm_pkg::cmd_t cmd;
    ccm_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    ccm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ccm_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .ref_x       (s_ref_x),
        .ref_y       (s_ref_y),
        .obj_x       (s_obj_x),
        .obj_y       (s_obj_y),
        .seg_weight  (s_seg_weight),
        .last_point  (s_last_point),
        .moment_xx   (m_moment_xx),
        .moment_yx   (m_moment_yx),
        .moment_xy   (m_moment_xy),
        .moment_yy   (m_moment_yy),
        .sine_term   (m_sine_term),
        .cosine_term (m_cosine_term),
        .closeness   (m_closeness)
    );

    a_one_point: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a point is in flight");

    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.out_load))
        else $error("result valid without a result load");

    a_sine: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_sine_term == (ccm_pkg::TermW'(m_moment_yx)
                                     - ccm_pkg::TermW'(m_moment_xy))))
        else $error("sine term disagrees with moments");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// Testbench for contour_cross_moment_matcher: directed table, random contours,
// a long full-scale contour, several lengths and idling phases; self-checking.
// Depends on ccm_pkg and the RTL top level only.
module testbench;

    typedef struct packed {
        logic signed [ccm_pkg::CoordW-1:0] ref_x;
        logic signed [ccm_pkg::CoordW-1:0] ref_y;
        logic signed [ccm_pkg::CoordW-1:0] obj_x;
        logic signed [ccm_pkg::CoordW-1:0] obj_y;
        logic [ccm_pkg::WeightW-1:0]       weight;
        logic                              last;
    } point_t;

    typedef struct packed {
        logic signed [ccm_pkg::MomW-1:0]  xx;
        logic signed [ccm_pkg::MomW-1:0]  yx;
        logic signed [ccm_pkg::MomW-1:0]  xy;
        logic signed [ccm_pkg::MomW-1:0]  yy;
        logic signed [ccm_pkg::TermW-1:0] sine;
        logic signed [ccm_pkg::TermW-1:0] cosine;
        logic [ccm_pkg::CloseW-1:0]       closeness;
    } match_t;

    typedef struct packed {
        point_t pt;
        logic   zero_result;
    } row_t;

    localparam longint SumMax = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint SumMin = 64'sh8000_0000_0000_0000;
    localparam int     LongContourPoints = 40;

    logic aclk;
    logic aresetn;
    logic cfg_valid;
    logic cfg_ready;
    logic [ccm_pkg::LenW-1:0] cfg_data;
    logic s_valid;
    logic s_ready;
    logic signed [ccm_pkg::CoordW-1:0] s_ref_x, s_ref_y, s_obj_x, s_obj_y;
    logic [ccm_pkg::WeightW-1:0] s_seg_weight;
    logic s_last_point;
    logic m_valid;
    logic m_ready;
    logic signed [ccm_pkg::MomW-1:0] m_moment_xx, m_moment_yx, m_moment_xy, m_moment_yy;
    logic signed [ccm_pkg::TermW-1:0] m_sine_term, m_cosine_term;
    logic [ccm_pkg::CloseW-1:0] m_closeness;

    contour_cross_moment_matcher uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_ref_x(s_ref_x), .s_ref_y(s_ref_y), .s_obj_x(s_obj_x), .s_obj_y(s_obj_y),
        .s_seg_weight(s_seg_weight), .s_last_point(s_last_point),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_moment_xx(m_moment_xx), .m_moment_yx(m_moment_yx),
        .m_moment_xy(m_moment_xy), .m_moment_yy(m_moment_yy),
        .m_sine_term(m_sine_term), .m_cosine_term(m_cosine_term),
        .m_closeness(m_closeness)
    );

    // predictor state
    logic [ccm_pkg::LenW-1:0] len_q;
    bit              first_q;
    int              first_ox, first_oy, prev_rx, prev_ry, prev_cx, prev_cy;
    longint          sums[ccm_pkg::MomCount];

    match_t expected_matches[$];
    int     errors;
    int     idle_pct;
    int     stall_pct;
    int     hold_cycles;
    int     hold_left = 0;
    bit     hold_used = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #40ms;
        $display("contour_cross_moment_matcher verification failed");
        $finish;
    end

    function automatic longint seg_moment(longint pr, longint cr, longint po, longint co,
                                          longint w);
        return (2 * (pr + cr) * (po + co) - pr * co - cr * po) * w;
    endfunction

    function automatic longint add_clamped(longint a, longint b);
        longint r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63]) r = a[63] ? SumMin : SumMax;
        return r;
    endfunction

    function automatic longint scale_moment(longint s, longint unsigned d);
        longint unsigned mag;
        logic [64:0]     q;
        mag = s[63] ? longint'(~s + 1) : s;
        q = ({1'b0, mag} + {1'b0, d / 2}) / {1'b0, d};
        if (s[63]) begin
            if (q > 65'd1073741824) q = 65'd1073741824;
            return -longint'(q[63:0]);
        end
        if (q > 65'd1073741823) q = 65'd1073741823;
        return longint'(q[63:0]);
    endfunction

    task automatic reset_predictor();
        len_q = 1;
        first_q = 1'b1;
        first_ox = 0; first_oy = 0; prev_rx = 0; prev_ry = 0; prev_cx = 0; prev_cy = 0;
        foreach (sums[i]) sums[i] = 0;
    endtask

    task automatic predict_match(point_t p, output bit have, output match_t r);
        int rx, ry, cx, cy;
        longint unsigned d, sa, ca;
        longint mxx, myx, mxy, myy, sn, cs;
        rx = p.ref_x; ry = p.ref_y;
        have = 1'b0;
        r = '0;
        if (first_q) begin
            first_q = 1'b0;
            first_ox = p.obj_x; first_oy = p.obj_y;
            prev_rx = rx; prev_ry = ry; prev_cx = 0; prev_cy = 0;
            foreach (sums[i]) sums[i] = 0;
        end else begin
            cx = int'(p.obj_x) - first_ox;
            cy = int'(p.obj_y) - first_oy;
            sums[0] = add_clamped(sums[0], seg_moment(prev_rx, rx, prev_cx, cx, p.weight));
            sums[1] = add_clamped(sums[1], seg_moment(prev_rx, rx, prev_cy, cy, p.weight));
            sums[2] = add_clamped(sums[2], seg_moment(prev_ry, ry, prev_cx, cx, p.weight));
            sums[3] = add_clamped(sums[3], seg_moment(prev_ry, ry, prev_cy, cy, p.weight));
            prev_rx = rx; prev_ry = ry; prev_cx = cx; prev_cy = cy;
        end
        if (!p.last) return;
        d = 6 * ((len_q == 0) ? 64'd1 : longint'(len_q));
        mxx = scale_moment(sums[0], d);
        myx = scale_moment(sums[1], d);
        mxy = scale_moment(sums[2], d);
        myy = scale_moment(sums[3], d);
        sn = myx - mxy;
        cs = mxx + myy;
        sa = sn < 0 ? -sn : sn;
        ca = cs < 0 ? -cs : cs;
        r.xx = mxx[ccm_pkg::MomW-1:0];
        r.yx = myx[ccm_pkg::MomW-1:0];
        r.xy = mxy[ccm_pkg::MomW-1:0];
        r.yy = myy[ccm_pkg::MomW-1:0];
        r.sine = sn[ccm_pkg::TermW-1:0];
        r.cosine = cs[ccm_pkg::TermW-1:0];
        r.closeness = sa * sa + ca * ca;
        first_q = 1'b1;
        have = 1'b1;
    endtask

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        match_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_matches.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got xx %h",
                         $time, m_moment_xx);
                errors++;
            end else begin
                e = expected_matches.pop_front();
                check_field("moment_xx", 64'(e.xx), 64'(m_moment_xx));
                check_field("moment_yx", 64'(e.yx), 64'(m_moment_yx));
                check_field("moment_xy", 64'(e.xy), 64'(m_moment_xy));
                check_field("moment_yy", 64'(e.yy), 64'(m_moment_yy));
                check_field("sine_term", 64'(e.sine), 64'(m_sine_term));
                check_field("cosine_term", 64'(e.cosine), 64'(m_cosine_term));
                check_field("closeness", e.closeness, m_closeness);
            end
        end
    end

    // receiver: random stalls, or one long hold-off when requested
    always @(negedge aclk) begin
        if (hold_cycles > 0 && !hold_used) begin
            hold_used <= 1'b1;
            hold_left <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_point(point_t p, bit zero_result);
        bit     have;
        match_t r;
        while ($urandom_range(99) < idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        {s_ref_x, s_ref_y, s_obj_x, s_obj_y, s_seg_weight, s_last_point} = p;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_match(p, have, r);
        if (zero_result) r = '0;
        if (have) expected_matches.push_back(r);
        @(negedge aclk);
    endtask

    task automatic write_length(logic [ccm_pkg::LenW-1:0] v);
        cfg_data = v;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        len_q = v;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (expected_matches.size() != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
    endtask

    function automatic logic [ccm_pkg::CoordW-1:0] pick_coord();
        case ($urandom_range(3))
            0: return ccm_pkg::CoordW'($urandom);
            1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return ccm_pkg::CoordW'($signed($urandom_range(0, 400)) - 200);
        endcase
    endfunction

    function automatic point_t random_point(bit last);
        point_t p;
        p.ref_x = pick_coord();
        p.ref_y = pick_coord();
        p.obj_x = pick_coord();
        p.obj_y = pick_coord();
        p.weight = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 3)) : 16'($urandom);
        p.last = last;
        return p;
    endfunction

    task automatic send_contours(int count);
        int n, k;
        while (count > 0) begin
            n = ($urandom_range(19) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8);
            for (k = 0; k < n; k++) send_point(random_point(k == n - 1), 1'b0);
            count -= n;
        end
    endtask

    row_t directed[] = '{
        '{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'hFFFF, 1'b1}, 1'b1},
        '{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'h0000, 1'b1}, 1'b1},
        '{'{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'h0000, 1'b0}, 1'b0},
        '{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 1'b1}, 1'b0},
        '{'{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'h1234, 1'b0}, 1'b0},
        '{'{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'hFFFF, 1'b1}, 1'b0},
        '{'{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'h0001, 1'b0}, 1'b0},
        '{'{16'sh0003, 16'sh0000, 16'sh0001, 16'sh0000, 16'h0001, 1'b0}, 1'b0},
        '{'{16'sh0003, 16'sh0004, 16'sh0001, 16'sh0002, 16'h0001, 1'b0}, 1'b0},
        '{'{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'h0001, 1'b1}, 1'b0},
        '{'{16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555, 16'h5555, 1'b0}, 1'b0},
        '{'{16'shAAAA, 16'sh5555, 16'sh5555, 16'shAAAA, 16'hAAAA, 1'b0}, 1'b0},
        '{'{16'shFFFF, 16'sh0001, 16'sh0001, 16'shFFFF, 16'h0000, 1'b1}, 1'b0},
        '{'{16'sh0010, 16'sh0020, 16'sh0030, 16'sh0040, 16'h0000, 1'b1}, 1'b1}
    };

    initial begin
        int ph;
        int i;
        logic [ccm_pkg::LenW-1:0] lens[5];
        point_t p;
        errors = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_valid = 1'b0;
        {s_ref_x, s_ref_y, s_obj_x, s_obj_y, s_seg_weight, s_last_point} = '0;
        m_ready = 1'b0;
        reset_predictor();
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (directed[j]) send_point(directed[j].pt, directed[j].zero_result);
        drain();

        lens = '{24'd3, 24'hFFFFFF, 24'd0, 24'($urandom_range(2, 5000)), 24'd1};
        for (ph = 0; ph < 5; ph++) begin
            write_length(lens[ph]);
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 62; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 62; end
                3: begin idle_pct = 22; stall_pct = 22; end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            if (ph == 4) begin
                // hold the receiver off while points keep coming
                hold_cycles = 3000;
                send_contours(60);
            end
            send_contours(150);
            drain();
        end

        // long contour at full scale
        idle_pct = 0;
        stall_pct = 0;
        write_length(24'd1);
        for (i = 0; i < LongContourPoints; i++) begin
            p.ref_x = 16'sh7FFF;
            p.ref_y = (i % 2) ? 16'sh7FFF : 16'sh8000;
            p.obj_x = (i == 0) ? 16'sh8000 : 16'sh7FFF;
            p.obj_y = (i == 0) ? 16'sh7FFF : 16'sh8000;
            p.weight = 16'hFFFF;
            p.last = (i == LongContourPoints - 1);
            send_point(p, 1'b0);
        end
        s_valid = 1'b0;
        while (expected_matches.size() != 0) @(negedge aclk);
        repeat (400) @(negedge aclk);
        if (errors == 0) begin
            $display("contour_cross_moment_matcher verification clean");
        end else begin
            $display("contour_cross_moment_matcher verification failed");
        end
        $finish;
    end
endmodule

### sim.f
rtl/ccm_pkg.sv
rtl/ccm_ctrl.sv
rtl/ccm_datapath.sv
rtl/contour_cross_moment_matcher.sv
test/testbench.sv
